[hw/rtl/pcps_pkg.sv]
// Shared widths, register indexes and compare setup type for the packed column scan.
package pcps_pkg;

  localparam int unsigned DATA_W  = 64;  // stream word width on both sides
  localparam int unsigned ENTRY_W = 5;   // entry_bits register width
  localparam int unsigned VALUE_W = 31;  // compare_value width, widest entry
  localparam int unsigned ADDR_W  = 2;   // config register index width

  localparam logic [ADDR_W-1:0] REG_ENTRY_BITS    = 2'd0;
  localparam logic [ADDR_W-1:0] REG_COMPARE_VALUE = 2'd1;
  localparam logic [ADDR_W-1:0] REG_COMPARE_MODE  = 2'd2;

  localparam logic MODE_NEQ = 1'b0;  // hit when entry differs from value
  localparam logic MODE_GE  = 1'b1;  // hit when entry is at least value

  // Compare setup shared by all lanes: value and mask aligned to the top of a window.
  typedef struct packed {
    logic [VALUE_W-1:0] top_mask;
    logic [VALUE_W-1:0] ref_val;
    logic               big;
    logic               mode;
  } cmp_cfg_t;

endpackage

[hw/rtl/pcps_lane.sv]
// One compare lane: tests the entry whose top bit sits at this lane's word position.
module pcps_lane (
  input  logic [pcps_pkg::VALUE_W-1:0] window_i,  // top bit is this lane's word bit
  input  pcps_pkg::cmp_cfg_t           cfg_i,
  output logic                         hit_o
);
  import pcps_pkg::*;

  logic [VALUE_W-1:0] masked;

  // Keep only the entry's bits; both sides carry zeros below them.
  assign masked = window_i & cfg_i.top_mask;

  always_comb begin
    if (cfg_i.mode == MODE_GE) begin
      hit_o = !cfg_i.big && (masked >= cfg_i.ref_val);
    end else begin
      hit_o = cfg_i.big || (masked != cfg_i.ref_val);
    end
  end

endmodule

[hw/rtl/pcps_merge.sv]
// Merge stage: keep lane hits at entry ends only and hold the result word for output.
module pcps_merge #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic [WORD_BITS-1:0]          hits_i,
  input  logic [WORD_BITS-1:0]          end_mask_i,
  input  logic                          m_axis_tready,
  output logic                          m_axis_tvalid,
  output logic [pcps_pkg::DATA_W-1:0]   m_axis_tdata
);
  import pcps_pkg::*;

  logic                valid_q, valid_d;
  logic [DATA_W-1:0]   data_q, data_d;

  always_comb begin
    data_d = '0;
    data_d[WORD_BITS-1:0] = hits_i & end_mask_i;
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      data_q <= data_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;

endmodule

[hw/rtl/packed_column_predicate_scan.sv]
// Packed column predicate scan: one WORD_BITS-wide word of packed entries per cycle unless the output stalls.
// An accepted input word's result word is registered and shows on the output register in the cycle after.
// Throughput: one word per cycle while the output register is not held; all WORD_BITS compare
//   lanes work in the same cycle and the split-entry carry is updated on every accepted word.
// Reset: carry cleared, entry_bits = 8, compare_value = 0, compare_mode = not-equal,
//   output register empty.
module packed_column_predicate_scan #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [pcps_pkg::ADDR_W-1:0]   cfg_addr_i,
  input  logic [pcps_pkg::VALUE_W-1:0]  cfg_wdata_i,
  // input words
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pcps_pkg::DATA_W-1:0]   s_axis_tdata,   // [63:0] data_word
  input  logic                          s_axis_tlast,   // last_word
  // result words
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pcps_pkg::DATA_W-1:0]   m_axis_tdata    // [63:0] result_word
);
  import pcps_pkg::*;

  // Virtual stream: carried bits (left-aligned in VALUE_W) sit directly below word bit 0.
  localparam int unsigned EXT_W = WORD_BITS + VALUE_W;
  // Entry-end pattern length covers every word bit shifted by up to VALUE_W-1 carried bits.
  localparam int unsigned PAT_W = WORD_BITS + VALUE_W - 1;
  localparam int unsigned NUM_E = 2 ** ENTRY_W;

  // Bit i of row e is set when an entry of width e ends at stream bit i.
  function automatic logic [NUM_E-1:0][PAT_W-1:0] build_pattern();
    logic [NUM_E-1:0][PAT_W-1:0] tbl;
    int unsigned                 cnt;
    tbl = '0;
    for (int unsigned e = 1; e < NUM_E; e++) begin
      cnt = 0;
      for (int unsigned i = 0; i < PAT_W; i++) begin
        cnt++;
        if (cnt == e) begin
          tbl[e][i] = 1'b1;
          cnt = 0;
        end
      end
    end
    return tbl;
  endfunction

  localparam logic [NUM_E-1:0][PAT_W-1:0]               PAT_TBL = build_pattern();

  // Config registers.
  logic [ENTRY_W-1:0] entry_bits_q;
  logic [VALUE_W-1:0] compare_value_q;
  logic               compare_mode_q;

  // Split-entry carry: bits left-aligned at the top of carry_bits_q.
  logic [VALUE_W-1:0] carry_bits_q, carry_bits_d;
  logic [ENTRY_W-1:0] carry_cnt_q, carry_cnt_d;

  logic                 fire;
  logic [WORD_BITS-1:0] word;
  logic [ENTRY_W-1:0]   skip;       // carried bits that really prefix this word
  logic [EXT_W-1:0]     ext;
  logic [PAT_W-1:0]     pat_shift;
  logic [WORD_BITS-1:0] end_mask;
  logic [WORD_BITS-1:0] hits;
  logic [ENTRY_W-1:0]   rem;
  cmp_cfg_t             cmp_cfg;

  // Accept a new word whenever the output register is free or drains this cycle.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_bits_q    <= ENTRY_W'(8);
      compare_value_q <= '0;
      compare_mode_q  <= MODE_NEQ;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ENTRY_BITS:    entry_bits_q    <= cfg_wdata_i[ENTRY_W-1:0];
        REG_COMPARE_VALUE: compare_value_q <= cfg_wdata_i;
        REG_COMPARE_MODE:  compare_mode_q  <= cfg_wdata_i[0];
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  assign word = s_axis_tdata[WORD_BITS-1:0];
  assign ext  = {word, carry_bits_q};

  // Drop a carry that no longer fits the current entry width.
  assign skip = (carry_cnt_q < entry_bits_q) ? carry_cnt_q : '0;

  // Entry ends in this word: pattern for the width, advanced by the carried bits.
  assign pat_shift = PAT_TBL[entry_bits_q] >> skip;
  assign end_mask  = pat_shift[WORD_BITS-1:0];

  // Leftover bits: distance from the last entry end in this word up to the word top.
  always_comb begin
    rem = '0;
    for (int unsigned i = 0; i < WORD_BITS; i++) begin
      if (end_mask[i]) begin
        rem = ENTRY_W'(WORD_BITS - 1 - i);
      end
    end
  end

  // Align the compare value with the top of a lane window; flag values no entry can reach.
  always_comb begin
    cmp_cfg.top_mask = ~({VALUE_W{1'b1}} >> entry_bits_q);
    cmp_cfg.ref_val  = compare_value_q << (ENTRY_W'(VALUE_W) - entry_bits_q);
    cmp_cfg.big      = (compare_value_q >> entry_bits_q) != '0;
    cmp_cfg.mode     = compare_mode_q;
  end

  // One lane per word bit; lane j sees the VALUE_W stream bits ending at word bit j.
  for (genvar j = 0; j < WORD_BITS; j++) begin : g_lane
    pcps_lane u_lane (
      .window_i (ext[j+VALUE_W:j+1]),
      .cfg_i    (cmp_cfg),
      .hit_o    (hits[j])
    );
  end

  pcps_merge #(
    .WORD_BITS (WORD_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .hits_i        (hits),
    .end_mask_i    (end_mask),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Carry the partial entry at the word top; clear it at column end, zero width or no leftover bits.
  always_comb begin
    carry_bits_d = carry_bits_q;
    carry_cnt_d  = carry_cnt_q;
    if (fire) begin
      if (s_axis_tlast || (entry_bits_q == '0) || (rem == '0)) begin
        carry_bits_d = '0;
        carry_cnt_d  = '0;
      end else begin
        carry_bits_d = word[WORD_BITS-1 -: VALUE_W];
        carry_cnt_d  = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_bits_q <= '0;
      carry_cnt_q  <= '0;
    end else begin
      carry_bits_q <= carry_bits_d;
      carry_cnt_q  <= carry_cnt_d;
    end
  end

endmodule

[dv/tb_packed_column_predicate_scan.sv]
// Self-checking testbench for the packed column predicate scan.
module tb_packed_column_predicate_scan;
  timeunit 1ns;
  timeprecision 1ps;

  import pcps_pkg::*;

  // Index 3 is not mapped; writes to it must leave the block untouched.
  localparam logic [ADDR_W-1:0] REG_SPARE = 2'd3;

  localparam int ITEMS_TARGET = 1650;   // stop opening new random phases past this
  localparam int PHASE_WORDS  = 100;    // words per random configuration phase
  localparam int HOLDOFF_LEN  = 300;    // long receiver hold-off, in cycles
  localparam int CYCLE_LIMIT  = 400000; // watchdog against a hung run

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } column_word_t;

  // Clock, reset and every block input start at known values.
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [ADDR_W-1:0]   cfg_addr_i  = '0;
  logic [VALUE_W-1:0]  cfg_wdata_i = '0;
  logic                s_tvalid    = 1'b0;
  logic                s_tready;
  logic [DATA_W-1:0]   s_tdata     = '0;
  logic                s_tlast     = 1'b0;
  logic                m_tvalid;
  logic                m_tready    = 1'b0;
  logic [DATA_W-1:0]   m_tdata;

  // Shadow of the configuration registers and of the split-entry carry.
  logic [ENTRY_W-1:0]  cfg_entry_bits = 5'd8;
  logic [VALUE_W-1:0]  cfg_value      = '0;
  logic                cfg_mode       = MODE_NEQ;
  logic [30:0]         carry_bits     = '0;
  logic [4:0]          carry_cnt      = '0;

  column_word_t        column_words[$];      // words waiting to be offered
  logic [DATA_W-1:0]   result_words_due[$];  // predicted result words, oldest first
  column_word_t        next_word;

  int words_queued    = 0;
  int words_taken     = 0;
  int results_seen    = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;
  int burst_left      = 0;
  int gap_left        = 0;
  int holdoff_left    = 0;
  int next_holdoff_at = 300;
  int pattern_left    = 0;
  int stall_pct       = 0;

  packed_column_predicate_scan #(
    .WORD_BITS(64)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Scan prediction
  // ---------------------------------------------------------------------------

  // Pull n bits of a word starting at pos; n never exceeds 31.
  function automatic logic [31:0] field_of(input logic [63:0] w, input int unsigned pos,
                                           input int unsigned n);
    return 32'((w >> pos) & ((64'd1 << n) - 64'd1));
  endfunction

  // Compare against the full 31-bit value: a value past the entry range is never equal and never reached.
  function automatic logic entry_hits(input logic [31:0] v);
    if (cfg_mode == MODE_GE) return v >= {1'b0, cfg_value};
    return v != {1'b0, cfg_value};
  endfunction

  // Scan one word: finish the split entry, walk whole entries, keep the leftover bits.
  function automatic logic [63:0] scan_word(input logic [63:0] w, input logic last);
    int unsigned e;
    int unsigned c;
    int unsigned p;
    int unsigned n;
    logic [31:0] v;
    logic [63:0] res;
    e   = cfg_entry_bits;
    c   = carry_cnt;
    p   = 0;
    res = '0;
    if (e == 0) begin
      // zero width: nothing to scan, drop the carry
      carry_bits = '0;
      carry_cnt  = '0;
      return '0;
    end
    // carry longer than an entry (width shrank mid-column): drop it
    if (c >= e) c = 0;
    if (c > 0) begin
      n = e - c;
      v = (32'(carry_bits) & ((32'd1 << c) - 32'd1)) | (field_of(w, 0, n) << c);
      if (entry_hits(v)) res[n-1] = 1'b1;
      p = n;
    end
    while (p + e <= 64) begin
      if (entry_hits(field_of(w, p, e))) res[p+e-1] = 1'b1;
      p += e;
    end
    // the final word's top bits are padding; otherwise they start the next entry
    if (p < 64 && !last) begin
      carry_bits = 31'(field_of(w, p, 64 - p));
      carry_cnt  = 5'(64 - p);
    end else begin
      carry_bits = '0;
      carry_cnt  = '0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: bursts of words with random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      // predict on acceptance so the carry follows the accepted order
      if (s_tvalid && s_tready) begin
        result_words_due.push_back(scan_word(s_tdata, s_tlast));
        words_taken++;
      end
      if (s_tvalid && !s_tready) begin
        // hold the offered word until it is taken
      end else if (gap_left != 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (column_words.size() != 0) begin
        next_word = column_words.pop_front();
        s_tdata  <= next_word.data;
        s_tlast  <= next_word.last;
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          // new burst; a third of them run straight on without a gap
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall density changes in segments; a long hold-off now and then
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left--;
      m_tready <= 1'b0;
    end else if (words_taken >= next_holdoff_at) begin
      // hold off long enough for the block to fill and push back on its input
      holdoff_left    = HOLDOFF_LEN;
      next_holdoff_at = next_holdoff_at + 700;
      m_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        pattern_left--;
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] exp_w,
                                 input logic [63:0] act_w);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("result word %0d: %s expected %h got %h", results_seen, what, exp_w, act_w);
  endtask

  // Check every accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (result_words_due.size() == 0) begin
        report_mismatch("unexpected word,", 'x, m_tdata);
      end else if (m_tdata !== result_words_due[0]) begin
        report_mismatch("result_word", result_words_due[0], m_tdata);
        void'(result_words_due.pop_front());
      end else begin
        void'(result_words_due.pop_front());
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_word(input logic [63:0] data, input logic last);
    column_words.push_back('{data: data, last: last});
    words_queued++;
  endtask

  // Wait until every queued word has produced its result, then let the pipe settle.
  task automatic drain_block();
    while (results_seen != words_queued) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [VALUE_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    case (addr)
      REG_ENTRY_BITS:    cfg_entry_bits = data[ENTRY_W-1:0];
      REG_COMPARE_VALUE: cfg_value      = data;
      REG_COMPARE_MODE:  cfg_mode       = data[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Queue one column. Most columns are packed from entries near the compare
  // value so that ties and boundary compares show up; the rest are raw words.
  task automatic queue_column(input int n_words, input bit close_it);
    logic [127:0] acc;
    logic [31:0]  lim;
    logic [31:0]  ent;
    logic [63:0]  word;
    int           nb;
    int           k;
    bit           packed_entries;
    acc = '0;
    nb  = 0;
    lim = (cfg_entry_bits == 0) ? 32'd0 : (32'd1 << cfg_entry_bits) - 32'd1;
    packed_entries = (cfg_entry_bits != 0) && ($urandom_range(0, 3) != 0);
    for (k = 0; k < n_words; k++) begin
      if (packed_entries) begin
        while (nb < 64) begin
          case ($urandom_range(0, 5))
            0, 1:    ent = {1'b0, cfg_value};
            2:       ent = {1'b0, cfg_value} + 32'd1;
            3:       ent = {1'b0, cfg_value} - 32'd1;
            4:       ent = $urandom_range(0, 1) ? lim : 32'd0;
            default: ent = $urandom;
          endcase
          acc = acc | ({96'd0, ent & lim} << nb);
          nb += cfg_entry_bits;
        end
        word = acc[63:0];
        acc  = acc >> 64;
        nb  -= 64;
      end else begin
        word = {$urandom, $urandom};
      end
      queue_word(word, close_it && (k == n_words - 1));
    end
  endtask

  initial begin : stimulus
    int          phase;
    int          phase_words;
    int          len;
    int unsigned ebits;
    logic [31:0] lim;
    logic [31:0] val;
    logic [30:0] junk;
    phase = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: 8-bit entries, not-equal against zero.
    queue_word(64'h0, 1'b0);
    queue_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    drain_block();

    // Widest entries against the top value; entries straddle every word.
    write_reg(REG_ENTRY_BITS, 31'd31);
    write_reg(REG_COMPARE_VALUE, 31'h7FFF_FFFF);
    write_reg(REG_COMPARE_MODE, 31'(MODE_GE));
    queue_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_word(64'h5555_5555_5555_5555, 1'b1);
    drain_block();

    // Single-bit entries.
    write_reg(REG_ENTRY_BITS, 31'd1);
    write_reg(REG_COMPARE_VALUE, 31'd1);
    write_reg(REG_COMPARE_MODE, 31'(MODE_NEQ));
    queue_word(64'h5555_5555_5555_5555, 1'b0);
    queue_word(64'hF0F0_F0F0_F0F0_F0F0, 1'b1);
    drain_block();

    // Compare value past the entry range: never equal, never reached.
    write_reg(REG_ENTRY_BITS, 31'd4);
    write_reg(REG_COMPARE_VALUE, 31'd16);
    queue_word(64'h0123_4567_89AB_CDEF, 1'b1);
    drain_block();
    write_reg(REG_COMPARE_MODE, 31'(MODE_GE));
    queue_word(64'hFEDC_BA98_7654_3210, 1'b1);
    drain_block();

    // Zero entry width: all-zero results, carry dropped.
    write_reg(REG_ENTRY_BITS, 31'd0);
    queue_word({$urandom, $urandom}, 1'b0);
    queue_word({$urandom, $urandom}, 1'b1);
    drain_block();

    // Leave four bits of carry, then shrink the entry below it mid-column.
    write_reg(REG_ENTRY_BITS, 31'd10);
    write_reg(REG_COMPARE_VALUE, 31'd5);
    queue_word(64'hFEDC_BA98_7654_3210, 1'b0);
    drain_block();
    write_reg(REG_ENTRY_BITS, 31'd3);
    queue_word(64'h9249_2492_4924_9249, 1'b1);
    drain_block();

    // Unmapped index must change nothing.
    write_reg(REG_ENTRY_BITS, 31'd5);
    write_reg(REG_COMPARE_VALUE, 31'd0);
    write_reg(REG_SPARE, 31'h7FFF_FFFF);
    queue_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    queue_word(64'h0, 1'b1);
    drain_block();

    // Random phases: new settings each time, columns of random length. A phase
    // may end mid-column so the carry crosses the next configuration change.
    while (words_queued < ITEMS_TARGET) begin
      if (phase % 9 == 4)      ebits = 0;
      else if (phase % 6 == 0) ebits = 31;
      else if (phase % 6 == 1) ebits = 1;
      else                     ebits = $urandom_range(2, 30);
      lim = (ebits == 0) ? 32'd0 : (32'd1 << ebits) - 32'd1;
      case ($urandom_range(0, 7))
        0:       val = 32'd0;
        1:       val = lim;
        2:       val = $urandom & 32'h7FFF_FFFF;
        3:       val = (ebits < 31) ? lim + 32'd1 : lim;
        default: val = $urandom_range(0, lim);
      endcase
      // junk above the used bits must be ignored
      junk = $urandom_range(0, 1) ? 31'($urandom) : 31'd0;
      write_reg(REG_ENTRY_BITS, (junk & ~31'h1F) | 31'(ebits));
      write_reg(REG_COMPARE_VALUE, val[30:0]);
      write_reg(REG_COMPARE_MODE, (junk & ~31'h1) | 31'($urandom_range(0, 1)));
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        queue_column(len, (phase_words + len < PHASE_WORDS) || ($urandom_range(0, 3) != 0));
        phase_words += len;
      end
      drain_block();
      phase++;
    end

    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && result_words_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pcps_pkg.sv
hw/rtl/pcps_lane.sv
hw/rtl/pcps_merge.sv
hw/rtl/packed_column_predicate_scan.sv
dv/tb_packed_column_predicate_scan.sv
